// ===== src/bba_pkg.sv =====
`default_nettype none
package bba_pkg;

  localparam int DEF_POOL_ORDER  = 10;
  localparam int DEF_GRAIN_ORDER = 4;
  localparam int SIZE_W          = 16;
  localparam int ADDR_W          = 32;
  localparam int ORD_W           = 5;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_A_POP,
    ST_A_SPLIT,
    ST_F_ORD,
    ST_F_CHK,
    ST_F_LNK,
    ST_OUT
  } state_t;

  // Number of significant bits in the size, which is the smallest order
  // whose block is strictly larger than the size.
  function automatic logic [ORD_W-1:0] size_order(input logic [SIZE_W-1:0] size);
    logic [ORD_W-1:0] res;
    res = '0;
    for (int i = 0; i < SIZE_W; i++) begin
      if (size[i]) begin
        res = ORD_W'(i + 1);
      end
    end
    return res;
  endfunction

endpackage
`default_nettype wire

// ===== src/bba_if.sv =====
`default_nettype none
interface bba_req_if;
  logic                         valid;
  logic                         ready;
  logic                         command;
  logic [bba_pkg::SIZE_W-1:0]   request_size;
  logic [bba_pkg::ADDR_W-1:0]   block_address;

  modport source (output valid, command, request_size, block_address, input ready);
  modport sink   (input valid, command, request_size, block_address, output ready);
endinterface

interface bba_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [bba_pkg::ADDR_W-1:0]   granted_address;
  logic                         success;

  modport source (output valid, granted_address, success, input ready);
  modport sink   (input valid, granted_address, success, output ready);
endinterface
`default_nettype wire

// ===== src/buddy_block_allocator.sv =====
`default_nettype none
// Binary buddy allocator over a pool of 2^POOL_ORDER bytes in minimum blocks of
// 2^GRAIN_ORDER bytes. Each request either allocates (command 0) or frees
// (command 1) and yields exactly one response; an allocation returns
// pool_base plus the block offset, a failed allocation and every free return
// address zero. The free lists live in a head register per order plus a
// next-link memory indexed by minimum block, and the order of each granted
// block sits in a second memory; both memories have a registered read and
// are not cleared, so no clearing pass follows reset. The one link that is
// live from reset, the null link of block zero on the top list, is supplied
// by a flag until that entry is first written. A failed allocation goes
// straight to the response register; a granted one pops its list head and
// then splits once per level down to the requested order. A free fetches
// its order, then at each order it climbs it searches that list for its
// buddy (at most 2^(POOL_ORDER-GRAIN_ORDER) entries examined, the buddy
// included). A new request is taken once the previous one has passed into
// the response register, so a slow consumer only stalls the block when a
// second response is ready.
module buddy_block_allocator #(
  parameter int POOL_ORDER  = bba_pkg::DEF_POOL_ORDER,
  parameter int GRAIN_ORDER = bba_pkg::DEF_GRAIN_ORDER
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_wr_en,
  input  wire logic [bba_pkg::ADDR_W-1:0] cfg_wr_data,
  bba_req_if.sink                         in_req,
  bba_rsp_if.source                       out_rsp
);

  localparam int SPAN   = (POOL_ORDER > GRAIN_ORDER) ? (POOL_ORDER - GRAIN_ORDER) : 0;
  localparam int TOP    = GRAIN_ORDER + SPAN;
  localparam int LEVELS = SPAN + 1;
  localparam int NBLK   = 1 << SPAN;
  localparam int BW     = (SPAN > 0) ? SPAN : 1;
  localparam int LW     = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int AW     = bba_pkg::ADDR_W;

  // Configuration.
  logic [AW-1:0] pool_base_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_base_r <= '0;
    end else if (cfg_wr_en) begin
      pool_base_r <= cfg_wr_data;
    end
  end

  // List heads: one valid bit and one block number per order.
  logic [LEVELS-1:0] head_vld_r;
  logic [BW-1:0]     head_blk_r [LEVELS];
  logic              hd_we;
  logic [LW-1:0]     hd_wlvl;
  logic              hd_wvld;
  logic [BW-1:0]     hd_wblk;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_vld_r <= LEVELS'(1) << SPAN;
      for (int l = 0; l < LEVELS; l++) begin
        head_blk_r[l] <= '0;
      end
    end else if (hd_we) begin
      head_vld_r[hd_wlvl] <= hd_wvld;
      head_blk_r[hd_wlvl] <= hd_wblk;
    end
  end

  // Next-link memory: valid bit above the block number.
  logic [BW:0]   lnk_mem [NBLK];
  logic          lnk_we;
  logic [BW-1:0] lnk_waddr;
  logic [BW:0]   lnk_wdata;
  logic [BW-1:0] lnk_raddr;
  logic [BW:0]   lnk_rdata_r;
  logic          lnk0_fresh_r;
  logic          lnk_rd0_r;
  logic [BW:0]   lnk_rdata;

  always_ff @(posedge clk) begin
    if (lnk_we) begin
      lnk_mem[lnk_waddr] <= lnk_wdata;
    end
    lnk_rdata_r <= lnk_mem[lnk_raddr];
    lnk_rd0_r   <= lnk0_fresh_r && (lnk_raddr == '0);
  end

  // Block zero holds a null link from reset until its entry is first written.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lnk0_fresh_r <= 1'b1;
    end else if (lnk_we && lnk_waddr == '0) begin
      lnk0_fresh_r <= 1'b0;
    end
  end

  assign lnk_rdata = lnk_rd0_r ? '0 : lnk_rdata_r;

  // Recorded order memory, held as a level above GRAIN_ORDER.
  logic [LW-1:0] ord_mem [NBLK];
  logic          ord_we;
  logic [BW-1:0] ord_waddr;
  logic [LW-1:0] ord_wdata;
  logic [BW-1:0] ord_raddr;
  logic [LW-1:0] ord_rdata_r;

  always_ff @(posedge clk) begin
    if (ord_we) begin
      ord_mem[ord_waddr] <= ord_wdata;
    end
    ord_rdata_r <= ord_mem[ord_raddr];
  end

  // Working registers.
  bba_pkg::state_t state_r, state_nxt;
  logic [BW-1:0]   blk_r, blk_nxt;
  logic [LW-1:0]   lvl_r, lvl_nxt;
  logic [LW-1:0]   tgt_r, tgt_nxt;
  logic [BW-1:0]   cur_r, cur_nxt;
  logic [BW-1:0]   prev_r, prev_nxt;
  logic            at_head_r, at_head_nxt;
  logic [BW-1:0]   steps_r, steps_nxt;
  logic [AW-1:0]   res_addr_r, res_addr_nxt;
  logic            res_ok_r, res_ok_nxt;
  logic            out_vld_r, out_vld_nxt;
  logic [AW-1:0]   out_addr_r, out_addr_nxt;
  logic            out_ok_r, out_ok_nxt;

  logic          in_fire;
  logic [AW-1:0] free_off;
  logic [BW-1:0] free_blk;
  logic [BW-1:0] lvl_mask;
  logic [BW-1:0] bud;
  logic [BW-1:0] split_bud;
  logic [LW-1:0] lvl_dn;

  assign in_req.ready = (state_r == bba_pkg::ST_IDLE);
  assign in_fire      = in_req.valid && in_req.ready;

  // The free offset drops its low bits and then wraps modulo the block count.
  assign free_off  = ((in_req.block_address - pool_base_r) >> GRAIN_ORDER) & AW'(NBLK - 1);
  assign free_blk  = BW'(free_off);
  assign lvl_mask  = BW'(1) << lvl_r;
  assign bud       = blk_r ^ lvl_mask;
  assign lvl_dn    = lvl_r - LW'(1);
  assign split_bud = blk_r ^ (BW'(1) << lvl_dn);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= bba_pkg::ST_IDLE;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    blk_r      <= blk_nxt;
    lvl_r      <= lvl_nxt;
    tgt_r      <= tgt_nxt;
    cur_r      <= cur_nxt;
    prev_r     <= prev_nxt;
    at_head_r  <= at_head_nxt;
    steps_r    <= steps_nxt;
    res_addr_r <= res_addr_nxt;
    res_ok_r   <= res_ok_nxt;
    out_addr_r <= out_addr_nxt;
    out_ok_r   <= out_ok_nxt;
  end

  always_comb begin
    int  ord_i;
    int  ol;
    int  lf;
    logic found;

    state_nxt    = state_r;
    blk_nxt      = blk_r;
    lvl_nxt      = lvl_r;
    tgt_nxt      = tgt_r;
    cur_nxt      = cur_r;
    prev_nxt     = prev_r;
    at_head_nxt  = at_head_r;
    steps_nxt    = steps_r;
    res_addr_nxt = res_addr_r;
    res_ok_nxt   = res_ok_r;
    out_vld_nxt  = out_vld_r && !out_rsp.ready;
    out_addr_nxt = out_addr_r;
    out_ok_nxt   = out_ok_r;

    hd_we     = 1'b0;
    hd_wlvl   = lvl_r;
    hd_wvld   = 1'b1;
    hd_wblk   = blk_r;
    lnk_we    = 1'b0;
    lnk_waddr = blk_r;
    lnk_wdata = {head_vld_r[lvl_r], head_blk_r[lvl_r]};
    lnk_raddr = cur_r;
    ord_we    = 1'b0;
    ord_waddr = blk_r;
    ord_wdata = tgt_r;
    ord_raddr = free_blk;

    ord_i = int'(bba_pkg::size_order(in_req.request_size));
    if (ord_i < GRAIN_ORDER) begin
      ord_i = GRAIN_ORDER;
    end
    ol    = ord_i - GRAIN_ORDER;
    found = 1'b0;
    lf    = 0;
    for (int l = LEVELS - 1; l >= 0; l--) begin
      if (l >= ol && head_vld_r[l]) begin
        found = 1'b1;
        lf    = l;
      end
    end

    unique case (state_r)
      bba_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (in_req.command == bba_pkg::CMD_FREE) begin
            blk_nxt   = free_blk;
            state_nxt = bba_pkg::ST_F_ORD;
          end else if (ord_i > TOP || !found) begin
            res_addr_nxt = '0;
            res_ok_nxt   = 1'b0;
            state_nxt    = bba_pkg::ST_OUT;
          end else begin
            // Pop the head of the first non-empty list; its link arrives next.
            blk_nxt   = head_blk_r[LW'(lf)];
            lvl_nxt   = LW'(lf);
            tgt_nxt   = LW'(ol);
            lnk_raddr = head_blk_r[LW'(lf)];
            state_nxt = bba_pkg::ST_A_POP;
          end
        end
      end

      bba_pkg::ST_A_POP: begin
        hd_we   = 1'b1;
        hd_wlvl = lvl_r;
        hd_wvld = lnk_rdata[BW];
        hd_wblk = lnk_rdata[BW-1:0];
        if (lvl_r == tgt_r) begin
          ord_we       = 1'b1;
          res_addr_nxt = pool_base_r + (AW'(blk_r) << GRAIN_ORDER);
          res_ok_nxt   = 1'b1;
          state_nxt    = bba_pkg::ST_OUT;
        end else begin
          state_nxt = bba_pkg::ST_A_SPLIT;
        end
      end

      bba_pkg::ST_A_SPLIT: begin
        // The upper half goes onto the empty list one order down.
        lnk_we    = 1'b1;
        lnk_waddr = split_bud;
        lnk_wdata = '0;
        hd_we     = 1'b1;
        hd_wlvl   = lvl_dn;
        hd_wvld   = 1'b1;
        hd_wblk   = split_bud;
        lvl_nxt   = lvl_dn;
        if (lvl_dn == tgt_r) begin
          ord_we       = 1'b1;
          res_addr_nxt = pool_base_r + (AW'(blk_r) << GRAIN_ORDER);
          res_ok_nxt   = 1'b1;
          state_nxt    = bba_pkg::ST_OUT;
        end
      end

      bba_pkg::ST_F_ORD: begin
        if (int'(ord_rdata_r) > SPAN) begin
          lvl_nxt = LW'(SPAN);
        end else begin
          lvl_nxt = ord_rdata_r;
        end
        state_nxt = bba_pkg::ST_F_CHK;
      end

      bba_pkg::ST_F_CHK: begin
        if (int'(lvl_r) >= SPAN || !head_vld_r[lvl_r]) begin
          // Push the block: it cannot merge any further.
          lnk_we       = 1'b1;
          hd_we        = 1'b1;
          res_addr_nxt = '0;
          res_ok_nxt   = 1'b1;
          state_nxt    = bba_pkg::ST_OUT;
        end else begin
          cur_nxt     = head_blk_r[lvl_r];
          lnk_raddr   = head_blk_r[lvl_r];
          at_head_nxt = 1'b1;
          steps_nxt   = '0;
          state_nxt   = bba_pkg::ST_F_LNK;
        end
      end

      bba_pkg::ST_F_LNK: begin
        if (cur_r == bud) begin
          // Buddy found: unlink it and merge towards the lower address.
          if (at_head_r) begin
            hd_we   = 1'b1;
            hd_wvld = lnk_rdata[BW];
            hd_wblk = lnk_rdata[BW-1:0];
          end else begin
            lnk_we    = 1'b1;
            lnk_waddr = prev_r;
            lnk_wdata = lnk_rdata;
          end
          blk_nxt   = blk_r & ~lvl_mask;
          lvl_nxt   = lvl_r + LW'(1);
          state_nxt = bba_pkg::ST_F_CHK;
        end else if (!lnk_rdata[BW] || steps_r == BW'(NBLK - 1)) begin
          lnk_we       = 1'b1;
          hd_we        = 1'b1;
          res_addr_nxt = '0;
          res_ok_nxt   = 1'b1;
          state_nxt    = bba_pkg::ST_OUT;
        end else begin
          prev_nxt    = cur_r;
          cur_nxt     = lnk_rdata[BW-1:0];
          lnk_raddr   = lnk_rdata[BW-1:0];
          at_head_nxt = 1'b0;
          steps_nxt   = steps_r + BW'(1);
        end
      end

      bba_pkg::ST_OUT: begin
        if (!out_vld_r || out_rsp.ready) begin
          out_vld_nxt  = 1'b1;
          out_addr_nxt = res_addr_r;
          out_ok_nxt   = res_ok_r;
          state_nxt    = bba_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = bba_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_rsp.valid           = out_vld_r;
  assign out_rsp.granted_address = out_addr_r;
  assign out_rsp.success         = out_ok_r;

  // A failed allocation never carries an address.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_ok_r |-> out_addr_r == '0)
    else $error("failed response carries an address");

  // A split always stays above the requested order.
  a_split_lvl: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == bba_pkg::ST_A_SPLIT |-> lvl_r > tgt_r)
    else $error("split below the requested order");

  // A list walk never happens at the top order.
  a_walk_lvl: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == bba_pkg::ST_F_LNK |-> int'(lvl_r) < SPAN)
    else $error("list walk at the top order");

  // One request at a time: acceptance closes the input until it is done.
  a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_req.ready)
    else $error("second request taken while busy");

endmodule
`default_nettype wire
